// ===== rtl/core/sql_keyword_tokenizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// sql keyword tokenizer assertion macros
// concurrent checks on a clock with synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef SQL_KEYWORD_TOKENIZER_TOP_MACROS_SVH
`define SQL_KEYWORD_TOKENIZER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// consequent checked in the same cycle as the antecedent
`define SQLKT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SQLKT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SQLKT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define SQLKT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/core/sqlkt_pkg.sv =====
// ----------------------------------------------------------------------------
// sqlkt_pkg
// shared types, token codes, keyword table and character helpers for the
// sql keyword tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package sqlkt_pkg;

    // default sizing
    localparam int DEF_WORD_BUFFER_DEPTH = 16;
    localparam int DEF_TEXT_CAPACITY     = 65536;

    // most results one request can cause
    localparam int MAX_RES = 3;

    // longest keyword text and number of table entries
    localparam int KW_SPAN = 14;
    localparam int KW_NUM  = 29;

    // the split word gives two tokens
    localparam logic [KW_SPAN*8-1:0] SPLIT_WORD = {"AUTO", "_", "INCREMENT"};
    localparam logic [15:0] SPLIT_FIRST_LEN     = 16'd4;
    localparam logic [15:0] SPLIT_SECOND_LEN    = 16'd9;
    localparam int          SPLIT_SECOND_OFFSET = 5;

    // character codes
    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // token kinds
    typedef enum logic [5:0] {
        KIND_IDENT, KIND_NUMBER, KIND_STRING, KIND_SELECT, KIND_FROM,
        KIND_WHERE, KIND_AND, KIND_OR, KIND_ORDER, KIND_GROUP, KIND_BY,
        KIND_CREATE, KIND_DATABASE, KIND_TABLE, KIND_IN, KIND_PRIMARY,
        KIND_KEY, KIND_UNIQUE, KIND_NOT, KIND_NULL, KIND_AUTO,
        KIND_INCREMENT, KIND_INSERT, KIND_INTO, KIND_VALUES, KIND_UPDATE,
        KIND_SET, KIND_DELETE, KIND_USE, KIND_EXIT, KIND_PLUS, KIND_MINUS,
        KIND_STAR, KIND_SLASH, KIND_EQ, KIND_LT, KIND_GT, KIND_LTEQ,
        KIND_GTEQ, KIND_COMMA, KIND_SEMI, KIND_LPAREN, KIND_RPAREN, KIND_END
    } kind_t;

    // result status
    typedef enum logic [1:0] {
        ST_OK, ST_OPEN_STRING, ST_UNKNOWN_BYTE, ST_TOO_LONG
    } status_t;

    // scanner state
    typedef enum logic [3:0] {
        MODE_IDLE, MODE_WORD, MODE_INT, MODE_FRAC, MODE_STR, MODE_ESC,
        MODE_LT, MODE_GT, MODE_ERR
    } mode_t;

    // one result
    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        status_t     status;
    } result_t;

    // all results of one request, count is 1 to MAX_RES when loaded
    typedef struct packed {
        logic [1:0]                count;
        result_t [MAX_RES-1:0]     res;
    } bundle_t;

    // keyword table entry, text right-justified
    typedef struct packed {
        logic [KW_SPAN*8-1:0] txt;
        logic [3:0]           len;
        kind_t                kind;
        logic                 split;
    } kw_entry_t;

    // keyword lookup result
    typedef struct packed {
        logic  hit;
        logic  split;
        kind_t kind;
    } kw_hit_t;

    localparam kw_entry_t KW_TABLE [KW_NUM] = '{
        '{"SELECT",   4'd6, KIND_SELECT,   1'b0},
        '{"FROM",     4'd4, KIND_FROM,     1'b0},
        '{"WHERE",    4'd5, KIND_WHERE,    1'b0},
        '{"AND",      4'd3, KIND_AND,      1'b0},
        '{"OR",       4'd2, KIND_OR,       1'b0},
        '{"ORDER",    4'd5, KIND_ORDER,    1'b0},
        '{"GROUP",    4'd5, KIND_GROUP,    1'b0},
        '{"BY",       4'd2, KIND_BY,       1'b0},
        '{"CREATE",   4'd6, KIND_CREATE,   1'b0},
        '{"DATABASE", 4'd8, KIND_DATABASE, 1'b0},
        '{"TABLE",    4'd5, KIND_TABLE,    1'b0},
        '{"IN",       4'd2, KIND_IN,       1'b0},
        '{"PRIMARY",  4'd7, KIND_PRIMARY,  1'b0},
        '{"KEY",      4'd3, KIND_KEY,      1'b0},
        '{"UNIQUE",   4'd6, KIND_UNIQUE,   1'b0},
        '{"NOT",      4'd3, KIND_NOT,      1'b0},
        '{"NULL",     4'd4, KIND_NULL,     1'b0},
        '{"AUTO",     4'd4, KIND_AUTO,     1'b0},
        '{"INCREMENT", 4'd9, KIND_INCREMENT, 1'b0},
        '{"INSERT",   4'd6, KIND_INSERT,   1'b0},
        '{"INTO",     4'd4, KIND_INTO,     1'b0},
        '{"VALUES",   4'd6, KIND_VALUES,   1'b0},
        '{"UPDATE",   4'd6, KIND_UPDATE,   1'b0},
        '{"SET",      4'd3, KIND_SET,      1'b0},
        '{"DELETE",   4'd6, KIND_DELETE,   1'b0},
        '{"USE",      4'd3, KIND_USE,      1'b0},
        '{"EXIT",     4'd4, KIND_EXIT,     1'b0},
        '{"QUIT",     4'd4, KIND_EXIT,     1'b0},
        '{SPLIT_WORD, 4'd14, KIND_AUTO,    1'b1}
    };

    // character classes
    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b >= CH_HT && b <= CH_CR) || b == CH_SPACE;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return (b >= CH_LO_A && b <= CH_LO_Z) ? b - CASE_GAP : b;
    endfunction

    function automatic result_t make_result(input kind_t k, input logic [15:0] s,
                                            input logic [15:0] l, input status_t st);
        result_t r;
        r.kind   = k;
        r.start  = s;
        r.length = l;
        r.status = st;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sqlkt_kw_match.sv =====
// ----------------------------------------------------------------------------
// sqlkt_kw_match
// parallel compare of the buffered upper-case word against the keyword table
// ----------------------------------------------------------------------------
`default_nettype none

module sqlkt_kw_match
    import sqlkt_pkg::*;
#(
    parameter int CNT_W = 5
) (
    input  logic [KW_SPAN-1:0][7:0] letters,
    input  logic [CNT_W-1:0]        word_count,
    output kw_hit_t                 kw_hit
);

    // every entry compared at once, at most one can match
    always_comb begin
        logic eq;
        int   base;
        kw_hit = '{hit: 1'b0, split: 1'b0, kind: KIND_IDENT};
        for (int k = 0; k < KW_NUM; k++) begin
            eq = (word_count == CNT_W'(KW_TABLE[k].len));
            for (int i = 0; i < KW_SPAN; i++) begin
                base = (i < int'(KW_TABLE[k].len)) ? int'(KW_TABLE[k].len) - 1 - i : 0;
                if (i < int'(KW_TABLE[k].len)) begin
                    eq = eq && (letters[i] == KW_TABLE[k].txt[base*8 +: 8]);
                end
            end
            if (eq) begin
                kw_hit.hit   = 1'b1;
                kw_hit.split = KW_TABLE[k].split;
                kw_hit.kind  = KW_TABLE[k].kind;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sqlkt_scan.sv =====
// ----------------------------------------------------------------------------
// sqlkt_scan
// scanner state, word buffer and the single-pass decode that turns one
// request into up to three results
// ----------------------------------------------------------------------------
`default_nettype none
`include "sql_keyword_tokenizer_top_macros.svh"

module sqlkt_scan
    import sqlkt_pkg::*;
#(
    parameter int WORD_BUFFER_DEPTH = DEF_WORD_BUFFER_DEPTH,
    parameter int TEXT_CAPACITY     = DEF_TEXT_CAPACITY
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] char_byte,
    input  logic       end_of_text,
    output bundle_t    bundle
);

    localparam int POS_W = $clog2(TEXT_CAPACITY + 1);
    localparam int CNT_W = $clog2(WORD_BUFFER_DEPTH + 2);
    localparam int IDX_W = $clog2(WORD_BUFFER_DEPTH);
    localparam int EXT_W = (POS_W > 16) ? POS_W : 17;

    mode_t              mode_reg, mode_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   origin_reg, origin_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         letters_reg [WORD_BUFFER_DEPTH];

    logic               letter_we;
    logic [IDX_W-1:0]   letter_addr;
    logic [7:0]         letter_data;

    logic [KW_SPAN-1:0][7:0] word_view;
    kw_hit_t            kw_hit;

    logic               b_word_start, b_word, b_digit;
    logic               too_long;
    logic [15:0]        len_sat;
    logic               op_hit;
    kind_t              op_kind;

    mode_t              fr_mode;
    logic [POS_W-1:0]   fr_origin;
    logic               fr_tok_valid;
    result_t            fr_tok;
    logic               do_fresh;

    logic [1:0]         pend_cnt;
    result_t            pend0, pend1;
    logic               tail_valid;
    result_t            tail;
    logic [1:0]         flush_cnt;

    // clamp a position or length to the 16-bit result fields
    function automatic logic [15:0] sat16(input logic [POS_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return (e > EXT_W'(17'h0FFFF)) ? 16'hFFFF : e[15:0];
    endfunction

    // keyword compare on the stored word
    always_comb begin
        for (int i = 0; i < KW_SPAN; i++) begin
            word_view[i] = letters_reg[i];
        end
    end

    sqlkt_kw_match #(
        .CNT_W (CNT_W)
    ) u_kw_match (
        .letters    (word_view),
        .word_count (count_reg),
        .kw_hit     (kw_hit)
    );

    // byte classes
    assign b_digit      = is_digit(char_byte);
    assign b_word_start = is_alpha(char_byte) || char_byte == CH_USCORE;
    assign b_word       = b_word_start || b_digit;
    assign too_long     = pos_reg >= POS_W'(TEXT_CAPACITY);
    assign len_sat      = sat16(pos_reg - origin_reg);

    // single-character operators
    always_comb begin
        op_hit  = 1'b1;
        op_kind = KIND_PLUS;
        unique case (char_byte)
            CH_PLUS:   op_kind = KIND_PLUS;
            CH_MINUS:  op_kind = KIND_MINUS;
            CH_STAR:   op_kind = KIND_STAR;
            CH_SLASH:  op_kind = KIND_SLASH;
            CH_EQ:     op_kind = KIND_EQ;
            CH_COMMA:  op_kind = KIND_COMMA;
            CH_SEMI:   op_kind = KIND_SEMI;
            CH_LPAREN: op_kind = KIND_LPAREN;
            CH_RPAREN: op_kind = KIND_RPAREN;
            default:   op_hit  = 1'b0;
        endcase
    end

    // handling of a byte that starts afresh between tokens
    always_comb begin
        fr_mode      = MODE_ERR;
        fr_origin    = pos_reg;
        fr_tok_valid = 1'b0;
        fr_tok       = make_result(KIND_IDENT, sat16(pos_reg), 16'd0, ST_UNKNOWN_BYTE);
        if (is_space(char_byte)) begin
            fr_mode = MODE_IDLE;
        end else if (b_word_start) begin
            fr_mode = MODE_WORD;
        end else if (b_digit) begin
            fr_mode = MODE_INT;
        end else if (char_byte == CH_QUOTE) begin
            fr_mode   = MODE_STR;
            fr_origin = pos_reg + POS_W'(1);
        end else if (op_hit) begin
            fr_mode      = MODE_IDLE;
            fr_tok_valid = 1'b1;
            fr_tok       = make_result(op_kind, sat16(pos_reg), 16'd1, ST_OK);
        end else if (char_byte == CH_LT) begin
            fr_mode = MODE_LT;
        end else if (char_byte == CH_GT) begin
            fr_mode = MODE_GT;
        end else begin
            fr_tok_valid = 1'b1;
        end
    end

    // does this byte end the pending token and start afresh
    always_comb begin
        do_fresh = 1'b0;
        if (!end_of_text && mode_reg != MODE_ERR && !too_long) begin
            unique case (mode_reg) inside
                MODE_IDLE:        do_fresh = 1'b1;
                MODE_WORD:        do_fresh = !b_word;
                MODE_INT:         do_fresh = !b_digit && char_byte != CH_DOT;
                MODE_FRAC:        do_fresh = !b_digit;
                MODE_LT, MODE_GT: do_fresh = char_byte != CH_EQ;
                default:          do_fresh = 1'b0;
            endcase
        end
    end

    // next state of the scanner
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        origin_next = origin_reg;
        count_next  = count_reg;
        letter_we   = 1'b0;
        letter_addr = count_reg[IDX_W-1:0];
        letter_data = to_upper(char_byte);
        if (end_of_text) begin
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            origin_next = '0;
            count_next  = '0;
        end else if (mode_reg == MODE_ERR) begin
            mode_next = MODE_ERR;
        end else if (too_long) begin
            mode_next = MODE_ERR;
        end else begin
            pos_next = pos_reg + POS_W'(1);
            if (do_fresh) begin
                mode_next   = fr_mode;
                origin_next = fr_origin;
                if (fr_mode == MODE_WORD) begin
                    letter_we   = 1'b1;
                    letter_addr = '0;
                    count_next  = CNT_W'(1);
                end
            end else begin
                unique case (mode_reg) inside
                    MODE_WORD: begin
                        if (count_reg < CNT_W'(WORD_BUFFER_DEPTH)) begin
                            letter_we  = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end else begin
                            count_next = CNT_W'(WORD_BUFFER_DEPTH + 1);
                        end
                    end
                    MODE_INT: begin
                        if (char_byte == CH_DOT) begin
                            mode_next = MODE_FRAC;
                        end
                    end
                    MODE_STR: begin
                        if (char_byte == CH_QUOTE) begin
                            mode_next = MODE_IDLE;
                        end else if (char_byte == CH_BSLASH) begin
                            mode_next = MODE_ESC;
                        end
                    end
                    MODE_ESC:         mode_next = MODE_STR;
                    MODE_LT, MODE_GT: mode_next = MODE_IDLE;
                    default:          mode_next = mode_reg;
                endcase
            end
        end
    end

    // token left pending by the current mode
    always_comb begin
        pend_cnt = 2'd0;
        pend0    = make_result(KIND_IDENT, sat16(origin_reg), len_sat, ST_OK);
        pend1    = make_result(KIND_INCREMENT,
                               sat16(origin_reg + POS_W'(SPLIT_SECOND_OFFSET)),
                               SPLIT_SECOND_LEN, ST_OK);
        unique case (mode_reg) inside
            MODE_WORD: begin
                if (kw_hit.split) begin
                    pend_cnt = 2'd2;
                    pend0    = make_result(KIND_AUTO, sat16(origin_reg),
                                           SPLIT_FIRST_LEN, ST_OK);
                end else begin
                    pend_cnt = 2'd1;
                    pend0    = make_result(kw_hit.hit ? kw_hit.kind : KIND_IDENT,
                                           sat16(origin_reg), len_sat, ST_OK);
                end
            end
            MODE_INT, MODE_FRAC: begin
                pend_cnt = 2'd1;
                pend0    = make_result(KIND_NUMBER, sat16(origin_reg), len_sat, ST_OK);
            end
            MODE_STR, MODE_ESC: begin
                pend_cnt = 2'd1;
                pend0    = make_result(KIND_IDENT,
                                       (origin_reg != '0) ? sat16(origin_reg - POS_W'(1))
                                                          : 16'd0,
                                       16'd0, ST_OPEN_STRING);
            end
            MODE_LT: begin
                pend_cnt = 2'd1;
                pend0    = make_result(KIND_LT, sat16(origin_reg), 16'd1, ST_OK);
            end
            MODE_GT: begin
                pend_cnt = 2'd1;
                pend0    = make_result(KIND_GT, sat16(origin_reg), 16'd1, ST_OK);
            end
            default: pend_cnt = 2'd0;
        endcase
    end

    // closing result of this request
    always_comb begin
        tail_valid = 1'b0;
        tail       = make_result(KIND_END, sat16(pos_reg), 16'd0, ST_OK);
        if (end_of_text) begin
            tail_valid = 1'b1;
        end else if (mode_reg == MODE_ERR) begin
            tail_valid = 1'b0;
        end else if (too_long) begin
            tail_valid = 1'b1;
            tail       = make_result(KIND_IDENT, sat16(pos_reg), 16'd0, ST_TOO_LONG);
        end else if (do_fresh) begin
            tail_valid = fr_tok_valid;
            tail       = fr_tok;
        end else if (mode_reg == MODE_STR && char_byte == CH_QUOTE) begin
            tail_valid = 1'b1;
            tail       = make_result(KIND_STRING, sat16(origin_reg), len_sat, ST_OK);
        end else if (mode_reg == MODE_LT || mode_reg == MODE_GT) begin
            tail_valid = 1'b1;
            tail       = make_result((mode_reg == MODE_LT) ? KIND_LTEQ : KIND_GTEQ,
                                     sat16(origin_reg), 16'd2, ST_OK);
        end
    end

    // pack pending tokens then the closing result
    assign flush_cnt = (end_of_text || (do_fresh && mode_reg != MODE_IDLE)) ? pend_cnt
                                                                           : 2'd0;

    always_comb begin
        bundle.count  = flush_cnt + {1'b0, tail_valid};
        bundle.res[0] = (flush_cnt != 2'd0) ? pend0 : tail;
        bundle.res[1] = (flush_cnt == 2'd2) ? pend1 : tail;
        bundle.res[2] = tail;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            origin_reg <= '0;
            count_reg  <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            origin_reg <= origin_next;
            count_reg  <= count_next;
        end
    end

    // word buffer, only entries of the current word are ever read
    always_ff @(posedge aclk) begin
        if (accept && letter_we) begin
            letters_reg[letter_addr] <= letter_data;
        end
    end

    `SQLKT_ASSERT_SAME(a_end_gives_result, aclk, aresetn, accept && end_of_text, bundle.count != 2'd0, "end request produced no result")
    `SQLKT_ASSERT_SAME(a_err_drops_bytes, aclk, aresetn, accept && !end_of_text && mode_reg == MODE_ERR, bundle.count == 2'd0, "byte after error produced a result")

endmodule

`default_nettype wire

// ===== rtl/core/sqlkt_out.sv =====
// ----------------------------------------------------------------------------
// sqlkt_out
// result register holding one request's results and handing them out one
// per transfer on the master side
// ----------------------------------------------------------------------------
`default_nettype none
`include "sql_keyword_tokenizer_top_macros.svh"

module sqlkt_out
    import sqlkt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load_valid,
    input  bundle_t     load_bundle,
    output logic        take_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [7:0]  m_tuser,
    output logic        m_tlast
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    bundle_t    bundle_reg;
    result_t    cur;
    logic       at_last;

    // current result of the held bundle
    assign cur     = bundle_reg.res[idx_reg];
    assign at_last = idx_reg == (bundle_reg.count - 2'd1);

    // free once the last result is taken
    assign take_ready = !valid_reg || (m_tready && at_last);

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (take_ready) begin
            valid_next = load_valid;
            idx_next   = 2'd0;
        end else if (m_tready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_ready && load_valid) begin
            bundle_reg <= load_bundle;
        end
    end

    // master side
    assign m_tvalid = valid_reg;
    assign m_tdata  = {cur.length, cur.start};
    assign m_tuser  = {cur.status, cur.kind};
    assign m_tlast  = at_last;

    `SQLKT_ASSERT_NEXT(a_stall_holds, aclk, aresetn, valid_reg && !m_tready, valid_reg && $stable(idx_reg), "stalled result moved")
    `SQLKT_ASSERT_SAME(a_idx_in_range, aclk, aresetn, valid_reg, idx_reg < bundle_reg.count, "result index past bundle count")
    `SQLKT_ASSERT_SAME(a_load_when_free, aclk, aresetn, load_valid, take_ready, "bundle loaded while results still pending")

endmodule

`default_nettype wire

// ===== rtl/core/sql_keyword_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// sql_keyword_tokenizer_top
// streaming sql lexer: text bytes in, tokens (kind, start, length) out
// ----------------------------------------------------------------------------
// usage
// - slave side takes one request per transfer: s_tdata is a text byte, s_tlast
//   marks the end request that closes the statement (its byte is ignored)
// - master side gives one token per transfer; m_tlast marks the last token
//   caused by a request, requests that cause none give no transfer
// - a request is decoded in the cycle it is taken; its tokens are valid on
//   the master side from the next cycle, one per cycle while m_tready is high
// - throughput is one request per cycle while m_tready is high and no request
//   causes more than one token; a request causes at most three tokens (the
//   split word closed by the end request, an operator or a bad byte)
// - the slave side is taken again in the cycle the last held token leaves,
//   so a stalled receiver stalls s_tready only once the result register is full
// - reset clears scanner state, position and the result register at once,
//   no clearing pass; the end request returns the scanner to the same state
// - keyword compare runs in parallel over the stored word when a word ends
// ----------------------------------------------------------------------------
`default_nettype none

module sql_keyword_tokenizer_top
    import sqlkt_pkg::*;
#(
    parameter int WORD_BUFFER_DEPTH = DEF_WORD_BUFFER_DEPTH,
    parameter int TEXT_CAPACITY     = DEF_TEXT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] token_start, [31:16] token_length
    output logic [7:0]  m_tuser,   // [5:0] token_kind, [7:6] status
    output logic        m_tlast    // last_of_run
);

    logic    accept;
    logic    take_ready;
    bundle_t bundle;

    // request taken when the result register can take its tokens
    assign s_tready = take_ready;
    assign accept   = s_tvalid && take_ready;

    sqlkt_scan #(
        .WORD_BUFFER_DEPTH (WORD_BUFFER_DEPTH),
        .TEXT_CAPACITY     (TEXT_CAPACITY)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .char_byte   (s_tdata),
        .end_of_text (s_tlast),
        .bundle      (bundle)
    );

    sqlkt_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_valid  (accept && bundle.count != 2'd0),
        .load_bundle (bundle),
        .take_ready  (take_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire
